[rtl/core/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// rmf_pkg
// shared constants, types and register codes of the rgb median window filter
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int MAX_WINDOW_DEF  = 15;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int STORED_ROWS_DEF = 16;

  localparam int HEIGHT_LIMIT = 1024;
  localparam int ROW_W        = 10;
  localparam int CH_W         = 8;
  localparam int NUM_LANES    = 3;
  localparam int WS_W         = 4;
  localparam int DIM_W        = 11;
  localparam int RAD_W        = 3;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [WS_W-1:0]  WS_RESET = 4'd3;
  localparam logic [DIM_W-1:0] FW_RESET = 11'd640;
  localparam logic [DIM_W-1:0] FH_RESET = 11'd480;

  // one pixel, lane 0 red, lane 1 green, lane 2 blue
  typedef logic [NUM_LANES-1:0][CH_W-1:0] pix_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_FLUSH,
    ST_EXTRACT,
    ST_PUSH
  } state_e;

endpackage

[rtl/core/rmf_if.sv]
// ----------------------------------------------------------------------------
// rmf stream interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface rmf_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, op, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface rmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

[rtl/core/rgb_median_window_filter.sv]
// ----------------------------------------------------------------------------
// rgb_median_window_filter
// per channel median over a clipped square window of a raster rgb stream
// ----------------------------------------------------------------------------
// usage
//   in_i carries items: op 0 is a pixel in raster order, op 1 a drain tick
//   out_o carries filtered pixels in raster order, frame_end on the last
//   cfg_we_i/cfg_idx_i/cfg_data_i write window_size, frame_width, frame_height
//   while the block is idle; any write restarts the frame
//   pixels go into a ring of line buffers (one ram, one write and one read
//   port); once r rows and r pixels have arrived each pixel releases one
//   output, the tail of the frame comes out on drain ticks
//   one item at a time: an item with a window result passes setup, then
//   the window read, where the single ram read port feeds one pixel a cycle
//   into the sort chain, then a flush, the shift of the chain down to the
//   middle rank and the push; a clipped window holds up to 225 pixels
//   items without a result skip the walk, pass-through pixels go to the push
//   an invalid window size passes pixels through unchanged
//   reset clears position counters and loads the register defaults, the
//   line buffers keep no reset; a stalled receiver holds the output register
//   and the next item is taken while the result waits, up to the next push
// ----------------------------------------------------------------------------
module rgb_median_window_filter
  import rmf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int STORED_ROWS = STORED_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rmf_in_if.sink                in_i,
  rmf_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int EWW    = $clog2(MAX_WIDTH + 1);
  localparam int FWW    = (EWW > DIM_W) ? EWW : DIM_W;
  localparam int RGW    = $clog2(STORED_ROWS);
  localparam int RXW    = RGW + RAD_W;
  localparam int DEPTH  = STORED_ROWS * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int NCELLS = MAX_WINDOW * MAX_WINDOW;
  localparam int NW     = $clog2(NCELLS + 1);
  localparam int PW     = $clog2(MAX_WIDTH * HEIGHT_LIMIT) + 1;

  // configuration registers
  logic [WS_W-1:0]  ws_q;
  logic [DIM_W-1:0] fw_q, fh_q;

  // effective frame size and window radius
  logic [FWW-1:0]   fw_ext;
  logic [EWW-1:0]   eff_w;
  logic [DIM_W-1:0] eff_h;
  logic [CW-1:0]    w_m1;
  logic [ROW_W-1:0] h_m1;
  logic             ws_ok;
  logic [RAD_W-1:0] rad;
  logic [EWW-1:0]   min_rw;
  logic [PW-1:0]    lat;

  always_comb begin
    fw_ext = FWW'(fw_q);
    if (fw_q == '0) begin
      eff_w = EWW'(1);
    end else if (fw_ext > FWW'(MAX_WIDTH)) begin
      eff_w = EWW'(MAX_WIDTH);
    end else begin
      eff_w = EWW'(fw_q);
    end
    if (fh_q == '0) begin
      eff_h = DIM_W'(1);
    end else if (fh_q > DIM_W'(HEIGHT_LIMIT)) begin
      eff_h = DIM_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = fh_q;
    end
    w_m1  = CW'(eff_w - EWW'(1));
    h_m1  = ROW_W'(eff_h - DIM_W'(1));
    ws_ok = ws_q[0] && (ws_q >= WS_W'(3)) && ((WS_W + 1)'(ws_q) <= (WS_W + 1)'(MAX_WINDOW))
            && ((WS_W + 1)'(ws_q) + (WS_W + 1)'(1) <= (WS_W + 1)'(STORED_ROWS));
    rad   = ws_ok ? ws_q[WS_W-1:1] : '0;
    // output k leaves when input k + lat arrives
    min_rw = (EWW'(rad) < eff_w - EWW'(1)) ? EWW'(rad) : eff_w - EWW'(1);
    lat    = PW'(rad) * PW'(eff_w) + PW'(min_rw);
  end

  // position state
  logic [CW-1:0]    in_col_q, out_col_q;
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic [RGW-1:0]   in_ring_q, out_ring_q;
  logic [PW-1:0]    pix_q;
  logic             complete_q;

  // window walk
  logic [ROW_W-1:0] y_q, y1_q;
  logic [CW-1:0]    x_q, x0_q, x1_q;
  logic [RGW-1:0]   ring_q;
  logic             rd_pend_q;
  logic [NW-1:0]    n_q, j_q, k;
  pix_t             prev_q;

  // result and output registers
  pix_t res_q, out_q;
  logic res_end_q, out_end_q, out_vld_q;

  state_e state_q, state_d;

  logic in_acc, push, x_last, y_last, rank_hit, in_last, out_last;
  logic frame_restart;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign push       = (state_q == ST_PUSH) && (!out_vld_q || out_o.ready);
  assign x_last     = (x_q == x1_q);
  assign y_last     = (y_q == y1_q);
  assign k          = n_q >> 1;
  assign rank_hit   = (j_q == k);
  assign in_last    = (in_row_q == h_m1) && (in_col_q == w_m1);
  assign out_last   = (out_row_q == h_m1) && (out_col_q == w_m1);

  // line buffer
  pix_t          in_pix, rd_pix;
  logic          ram_we;
  logic [AW-1:0] waddr, raddr;

  assign in_pix[0] = in_i.in_red;
  assign in_pix[1] = in_i.in_green;
  assign in_pix[2] = in_i.in_blue;
  assign ram_we    = in_acc && (rad != '0) && !in_i.op && !complete_q;
  assign waddr     = AW'(in_ring_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  assign raddr     = AW'(ring_q) * AW'(MAX_WIDTH) + AW'(x_q);

  rmf_ram #(
    .WIDTH (NUM_LANES * CH_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (in_pix),
    .re_i    (state_q == ST_READ),
    .raddr_i (raddr),
    .rdata_o (rd_pix)
  );

  // sort chain, smallest value in cell 0
  cell_ctrl_t chain_ctrl;
  pix_t       cell_val [NCELLS];
  logic       cell_vld [NCELLS];

  assign chain_ctrl.clear  = (state_q == ST_SETUP);
  assign chain_ctrl.insert = rd_pend_q;
  assign chain_ctrl.shift  = (state_q == ST_EXTRACT);

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    pix_t lv, rv;
    logic lvl, rvl;
    if (i == 0) begin : g_first
      assign lv  = '0;
      assign lvl = 1'b1;
    end else begin : g_mid_l
      assign lv  = cell_val[i-1];
      assign lvl = cell_vld[i-1];
    end
    if (i == NCELLS - 1) begin : g_last
      assign rv  = '0;
      assign rvl = 1'b0;
    end else begin : g_mid_r
      assign rv  = cell_val[i+1];
      assign rvl = cell_vld[i+1];
    end
    rmf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (chain_ctrl),
      .x_i         (rd_pix),
      .left_val_i  (lv),
      .left_vld_i  (lvl),
      .right_val_i (rv),
      .right_vld_i (rvl),
      .val_o       (cell_val[i]),
      .vld_o       (cell_vld[i])
    );
  end

  // median of the middle rank, or floor average of the two middle ranks
  pix_t med;
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (n_q[0]) begin
        med[l] = cell_val[0][l];
      end else begin
        med[l] = CH_W'(((CH_W + 1)'(prev_q[l]) + (CH_W + 1)'(cell_val[0][l])) >> 1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (rad == '0) begin
            if (!in_i.op) begin
              state_d = ST_PUSH;
            end
          end else if (complete_q) begin
            state_d = ST_SETUP;
          end else if (!in_i.op && (pix_q >= lat)) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP:   state_d = ST_READ;
      ST_READ: begin
        if (x_last && y_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH:   state_d = ST_EXTRACT;
      ST_EXTRACT: begin
        if (rank_hit) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // window bounds for the current output position
  logic [RAD_W-1:0]   d_y;
  logic [DIM_W-1:0]   y_hi;
  logic [CW:0]        x_hi;
  logic [RXW-1:0]     ring0;
  always_comb begin
    d_y   = (out_row_q > ROW_W'(rad)) ? rad : RAD_W'(out_row_q);
    y_hi  = DIM_W'(out_row_q) + DIM_W'(rad);
    x_hi  = (CW + 1)'(out_col_q) + (CW + 1)'(rad);
    if (RXW'(out_ring_q) >= RXW'(d_y)) begin
      ring0 = RXW'(out_ring_q) - RXW'(d_y);
    end else begin
      ring0 = RXW'(out_ring_q) + RXW'(STORED_ROWS) - RXW'(d_y);
    end
  end

  assign frame_restart = (cfg_we_i && (cfg_idx_i == CFG_WINDOW_SIZE
                           || cfg_idx_i == CFG_FRAME_WIDTH || cfg_idx_i == CFG_FRAME_HEIGHT))
                         || ((state_q == ST_EXTRACT) && rank_hit && out_last);

  // configuration and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q       <= WS_RESET;
      fw_q       <= FW_RESET;
      fh_q       <= FH_RESET;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
      pix_q      <= '0;
      complete_q <= 1'b0;
    end else if (frame_restart) begin
      // new frame after a register write or after the last output
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
      pix_q      <= '0;
      complete_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_SIZE:  ws_q <= cfg_data_i[WS_W-1:0];
          CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[DIM_W-1:0];
          CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
    end else begin
      if (in_acc && !in_i.op && !complete_q && (rad != '0 || !in_last)) begin
        if (in_last) begin
          // full frame stored, tail goes out on drain ticks
          complete_q <= 1'b1;
          in_col_q   <= '0;
          in_row_q   <= '0;
          in_ring_q  <= '0;
          pix_q      <= '0;
        end else if (in_col_q == w_m1) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + ROW_W'(1);
          in_ring_q <= (in_ring_q == RGW'(STORED_ROWS - 1)) ? '0 : in_ring_q + RGW'(1);
          pix_q     <= pix_q + PW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
          pix_q    <= pix_q + PW'(1);
        end
      end else if (in_acc && !in_i.op && (rad == '0)) begin
        // last pass-through pixel of the frame
        in_col_q  <= '0;
        in_row_q  <= '0;
        in_ring_q <= '0;
        pix_q     <= '0;
      end
      if ((state_q == ST_EXTRACT) && rank_hit) begin
        if (out_col_q == w_m1) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + ROW_W'(1);
          out_ring_q <= (out_ring_q == RGW'(STORED_ROWS - 1)) ? '0 : out_ring_q + RGW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
    end
  end

  // window walk, ranking and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      n_q       <= '0;
      j_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == ST_READ);
      if (state_q == ST_SETUP) begin
        n_q <= '0;
      end else if (rd_pend_q) begin
        n_q <= n_q + NW'(1);
      end
      if (state_q == ST_EXTRACT) begin
        j_q <= j_q + NW'(1);
      end else begin
        j_q <= '0;
      end
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        res_q     <= in_pix;
        res_end_q <= in_last;
      end
      ST_SETUP: begin
        y_q    <= out_row_q - ROW_W'(d_y);
        y1_q   <= (y_hi < DIM_W'(h_m1)) ? ROW_W'(y_hi) : h_m1;
        x_q    <= (out_col_q > CW'(rad)) ? out_col_q - CW'(rad) : '0;
        x0_q   <= (out_col_q > CW'(rad)) ? out_col_q - CW'(rad) : '0;
        x1_q   <= (x_hi < (CW + 1)'(w_m1)) ? CW'(x_hi) : w_m1;
        ring_q <= ring0[RGW-1:0];
      end
      ST_READ: begin
        if (x_last) begin
          x_q    <= x0_q;
          y_q    <= y_q + ROW_W'(1);
          ring_q <= (ring_q == RGW'(STORED_ROWS - 1)) ? '0 : ring_q + RGW'(1);
        end else begin
          x_q <= x_q + CW'(1);
        end
      end
      ST_EXTRACT: begin
        prev_q <= cell_val[0];
        if (rank_hit) begin
          res_q     <= med;
          res_end_q <= out_last;
        end
      end
      default: ;
    endcase
    if (push) begin
      out_q     <= res_q;
      out_end_q <= res_end_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_red   = out_q[0];
  assign out_o.out_green = out_q[1];
  assign out_o.out_blue  = out_q[2];
  assign out_o.frame_end = out_end_q;

  // the chain still holds the rank being read
  a_rank_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXTRACT |-> cell_vld[0])
    else $error("sort chain empty during rank read");

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXTRACT |-> j_q <= k)
    else $error("rank counter ran past the middle");

  a_read_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_FLUSH || state_q == ST_READ))
    else $error("ram data arrived outside the window walk");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(NCELLS))
    else $error("more pixels inserted than chain cells");

endmodule

[rtl/core/rmf_ram.sv]
// ----------------------------------------------------------------------------
// rmf_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/core/rmf_cell.sv]
// ----------------------------------------------------------------------------
// rmf_cell
// one slot of the insertion sort chain, three independent channel lanes
// ----------------------------------------------------------------------------
module rmf_cell
  import rmf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  pix_t       x_i,
  input  pix_t       left_val_i,
  input  logic       left_vld_i,
  input  pix_t       right_val_i,
  input  logic       right_vld_i,
  output pix_t       val_o,
  output logic       vld_o
);

  pix_t val_q, val_d;
  logic vld_q, vld_d;

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (ctrl_i.shift) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end else if (ctrl_i.insert) begin
      vld_d = vld_q | left_vld_i;
      for (int l = 0; l < NUM_LANES; l++) begin
        // larger neighbor moves up, or the new value lands here
        if (left_vld_i && (x_i[l] < left_val_i[l])) begin
          val_d[l] = left_val_i[l];
        end else if (!vld_q || (x_i[l] < val_q[l])) begin
          val_d[l] = x_i[l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

[verif/rmf_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmf_checker
// watches the pixel and result channels and the register port of the rgb
// median window filter, predicts each filtered pixel and compares it
// ----------------------------------------------------------------------------
module rmf_checker
  import rmf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rmf_in_if                     in_w,
  rmf_out_if                    out_w,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_cnt_o,
  output int                    pending_o
);

  localparam int ROWS = STORED_ROWS_DEF;
  localparam int MW   = MAX_WIDTH_DEF;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } filt_pix_t;

  filt_pix_t          filt_q[$];
  logic [23:0]        line_mem [0:ROWS*MW-1];
  logic [WS_W-1:0]    win_size;
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  int unsigned        in_col, in_row, out_col, out_row;
  bit                 frame_in_done;
  int                 fail_cnt;

  assign fail_cnt_o = fail_cnt;

  function automatic int unsigned win_radius();
    if (win_size[0] == 1'b0 || win_size < 3 || win_size > MAX_WINDOW_DEF) return 0;
    if (win_size + 1 > ROWS) return 0;
    return win_size / 2;
  endfunction

  task automatic restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    frame_in_done = 0;
  endtask

  function automatic int unsigned rank_value(input int unsigned hist[256], input int unsigned k);
    int unsigned acc;
    acc = 0;
    for (int v = 0; v < 256; v++) begin
      acc += hist[v];
      if (acc > k) return v;
    end
    return 255;
  endfunction

  // median of the clipped window around the next output position
  task automatic emit_median(input int unsigned w, input int unsigned h, input int unsigned r);
    int unsigned hist[3][256];
    int unsigned y0, y1, x0, x1, n, m;
    logic [23:0] p;
    logic [7:0]  med[3];
    filt_pix_t   e;
    foreach (hist[c, v]) hist[c][v] = 0;
    n  = 0;
    y0 = (out_row > r) ? out_row - r : 0;
    y1 = (out_row + r < h - 1) ? out_row + r : h - 1;
    x0 = (out_col > r) ? out_col - r : 0;
    x1 = (out_col + r < w - 1) ? out_col + r : w - 1;
    for (int unsigned y = y0; y <= y1; y++) begin
      for (int unsigned x = x0; x <= x1; x++) begin
        p = line_mem[(y % ROWS) * MW + x];
        hist[0][p[7:0]]++;
        hist[1][p[15:8]]++;
        hist[2][p[23:16]]++;
        n++;
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (n % 2) m = rank_value(hist[c], n / 2);
      else m = (rank_value(hist[c], n / 2 - 1) + rank_value(hist[c], n / 2)) / 2;
      med[c] = m[7:0];
    end
    e.red = med[0]; e.green = med[1]; e.blue = med[2];
    e.frame_end = (out_row == h - 1) && (out_col == w - 1);
    filt_q = {filt_q, e};
    if (e.frame_end) restart_frame();
    else if (out_col + 1 >= w) begin
      out_col = 0; out_row++;
    end else out_col++;
  endtask

  task automatic take_item(input logic op, input logic [23:0] pix);
    int unsigned w, h, r, p, lat;
    filt_pix_t   e;
    w = (width_reg == 0) ? 1 : ((width_reg > MW) ? MW : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
    r = win_radius();
    if (in_col >= w || in_row >= h || out_col >= w || out_row >= h) restart_frame();
    // invalid window: straight pass-through, drain ticks ignored
    if (r == 0) begin
      if (op) return;
      e.red = pix[7:0]; e.green = pix[15:8]; e.blue = pix[23:16];
      e.frame_end = (in_row == h - 1) && (in_col == w - 1);
      filt_q = {filt_q, e};
      if (e.frame_end) restart_frame();
      else if (in_col + 1 >= w) begin
        in_col = 0; in_row++;
      end else in_col++;
      return;
    end
    // drain tick, or a pixel arriving while the frame drains
    if (op || frame_in_done) begin
      if (frame_in_done) emit_median(w, h, r);
      return;
    end
    line_mem[(in_row % ROWS) * MW + in_col] = pix;
    p = in_row * w + in_col;
    if (p == w * h - 1) begin
      frame_in_done = 1; in_col = 0; in_row = 0;
    end else if (in_col + 1 >= w) begin
      in_col = 0; in_row++;
    end else in_col++;
    lat = r * w + ((r < w - 1) ? r : w - 1);
    if (p >= lat) emit_median(w, h, r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filt_pix_t e;
    if (!rst_ni) begin
      filt_q.delete();
      win_size   = WS_RESET;
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      restart_frame();
      fail_cnt   = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_SIZE:  win_size   = cfg_data_i[WS_W-1:0];
          CFG_FRAME_WIDTH:  width_reg  = cfg_data_i;
          CFG_FRAME_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
        if (cfg_idx_i == CFG_WINDOW_SIZE || cfg_idx_i == CFG_FRAME_WIDTH ||
            cfg_idx_i == CFG_FRAME_HEIGHT) restart_frame();
      end
      if (in_w.valid && in_w.ready)
        take_item(in_w.op, {in_w.in_blue, in_w.in_green, in_w.in_red});
      if (out_w.valid && out_w.ready) begin
        if (filt_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result r=%h g=%h b=%h end=%b", $realtime,
                     out_w.out_red, out_w.out_green, out_w.out_blue, out_w.frame_end);
        end else begin
          e = filt_q.pop_front();
          if (out_w.out_red !== e.red || out_w.out_green !== e.green ||
              out_w.out_blue !== e.blue || out_w.frame_end !== e.frame_end) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch exp r=%h g=%h b=%h end=%b got r=%h g=%h b=%h end=%b",
                       $realtime, e.red, e.green, e.blue, e.frame_end, out_w.out_red,
                       out_w.out_green, out_w.out_blue, out_w.frame_end);
          end
        end
      end
      pending_o = filt_q.size();
    end
  end

endmodule

[verif/rgb_median_window_filter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_median_window_filter_tb
// drives pixel frames, drain ticks and register settings into the filter
// with random gaps and stalls; rmf_checker predicts and compares the output
// ----------------------------------------------------------------------------
module rgb_median_window_filter_tb;
  import rmf_pkg::*;

  // cycles without any handshake before the run is called hung
  localparam int STALL_LIMIT = 20000;
  // settle time after the last expected item, covers a full 15x15 window
  localparam int SETTLE_CYCLES = 400;
  // pixel cap that never cuts a frame
  localparam int FULL_FRAME = 1 << 20;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_cnt;
  int                    pending;
  int                    idle_cycles;
  int                    rand_pixels;
  bit                    calm;       // phase without gaps or stalls

  rmf_in_if  in_if ();
  rmf_out_if out_if ();

  rgb_median_window_filter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  rmf_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_w       (in_if),
    .out_w      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog, restarted by every accepted item on either side
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall per item, none in calm phases
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
    end
  end

  // mostly random pixels, sometimes all-zero or all-ones
  function automatic logic [23:0] pick_pixel();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 24'h000000;
    if (sel == 1) return 24'hffffff;
    return 24'($urandom());
  endfunction

  // one item on the pixel channel; entered and left at a falling edge
  task automatic send_item(input logic op, input logic [23:0] pix);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.in_red   <= pix[7:0];
    in_if.in_green <= pix[15:8];
    in_if.in_blue  <= pix[23:16];
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // register writes only once every expected item is out and the block is quiet
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // write enable stays high, the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [3:0] ws, input logic [10:0] fw, input logic [10:0] fh);
    wait_quiet();
    write_reg(CFG_WINDOW_SIZE, {7'd0, ws});
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    cfg_we <= 1'b0;
  endtask

  // configure, then stream frames: pixels with stray drain ticks, then the
  // drain ticks that flush the tail, some of them replaced by dropped pixels
  task automatic run_phase(input logic [3:0] ws, input logic [10:0] fw, input logic [10:0] fh,
                           input int frames, input int unsigned max_pix,
                           input bit allow_break);
    int unsigned w, h, r, lat, stop_at, drains;
    bit broken;
    set_regs(ws, fw, fh);
    w = (fw == 0) ? 1 : ((fw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : fw);
    h = (fh == 0) ? 1 : ((fh > HEIGHT_LIMIT) ? HEIGHT_LIMIT : fh);
    r = (ws[0] && ws >= 3 && ws <= MAX_WINDOW_DEF) ? ws / 2 : 0;
    lat = r * w + ((r < w - 1) ? r : w - 1);
    for (int f = 0; f < frames; f++) begin
      broken  = allow_break && ($urandom_range(0, 7) == 0);
      stop_at = broken ? $urandom_range(0, w * h - 1)
                       : ((w * h > max_pix) ? max_pix : w * h);
      for (int unsigned i = 0; i < w * h; i++) begin
        if (i == stop_at) break;
        if ($urandom_range(0, 9) == 0) send_item(1'b1, pick_pixel());
        send_item(1'b0, pick_pixel());
        rand_pixels++;
      end
      if (broken) break;
      drains = (r == 0) ? $urandom_range(0, 1) : lat + $urandom_range(0, 2);
      for (int unsigned i = 0; i < drains; i++)
        send_item(($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1, pick_pixel());
    end
  endtask

  initial begin
    logic [3:0] ws;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_WINDOW_SIZE;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.op       = 1'b0;
    in_if.in_red   = '0;
    in_if.in_green = '0;
    in_if.in_blue  = '0;
    calm           = 1'b0;
    idle_cycles    = 0;
    rand_pixels    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: 3x3 frame with a 3x3 window
    set_regs(4'd3, 11'd3, 11'd3);
    send_item(1'b1, 24'h123456);          // drain before the frame is complete
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hffffff);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'hffffff);
    send_item(1'b0, 24'haa55aa);
    send_item(1'b0, 24'h55aa55);
    send_item(1'b0, 24'h0f0f0f);
    send_item(1'b0, 24'hf0f0f0);
    send_item(1'b0, 24'h808080);
    send_item(1'b0, 24'h7f7f7f);          // pixel during the drain acts as a tick
    send_item(1'b1, 24'h000000);
    send_item(1'b1, 24'h000000);
    send_item(1'b1, 24'h000000);
    send_item(1'b1, 24'h000000);          // nothing left to drain
    // even window: pixels pass through, a drain tick gives nothing
    set_regs(4'd4, 11'd2, 11'd2);
    send_item(1'b0, 24'hffffff);
    send_item(1'b1, 24'hffffff);
    send_item(1'b0, 24'h000000);
    send_item(1'b0, 24'h13579b);

    // extremes of the registers
    run_phase(4'd0, 11'd2047, 11'd1, 1, FULL_FRAME, 1'b0);   // width clipped, pass-through
    run_phase(4'd15, 11'd1, 11'd2000, 1, 100, 1'b0);         // tall frame, first rows only
    run_phase(4'd15, 11'd16, 11'd16, 1, FULL_FRAME, 1'b0);   // full 15x15 windows
    run_phase(4'd3, 11'd0, 11'd0, 3, FULL_FRAME, 1'b0);      // 1x1 frame
    run_phase(4'd14, 11'd5, 11'd4, 1, FULL_FRAME, 1'b0);     // even window
    run_phase(4'd1, 11'd3, 11'd2, 1, FULL_FRAME, 1'b0);      // window below 3

    // random frames, mostly well-formed, some cut short
    rand_pixels = 0;
    while (rand_pixels < 100) begin
      calm = ($urandom_range(0, 3) == 0);
      ws = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'(2 * $urandom_range(1, 3) + 1);
      run_phase(ws, 11'($urandom_range(1, 12)), 11'($urandom_range(1, 10)),
                $urandom_range(1, 2), FULL_FRAME, 1'b1);
    end
    calm = 1'b0;

    wait_quiet();
    if (fail_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
